// ===== rtl/rld_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rld_pkg
// Shared types and constants for the run-length byte decoder.
// ----------------------------------------------------------------------------
package rld_pkg;

    localparam logic [7:0]  REPEAT_BASE       = 8'hC0;
    localparam logic [5:0]  REPEAT_COUNT_MASK = 6'h3F;
    localparam logic [7:0]  REPEAT_MAX        = 8'd64;
    localparam logic [7:0]  LITERAL_BASE      = 8'h80;
    localparam logic [6:0]  LITERAL_COUNT_MASK = 7'h7F;
    localparam logic [7:0]  LITERAL_MAX       = 8'd128;
    localparam logic [15:0] PIXEL_LIMIT_RESET = 16'd576;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_tile;
    } t_in_item;

    typedef struct packed {
        logic        pixel_valid;
        logic [7:0]  pixel_value;
        logic        last_of_item;
        logic        tile_done;
        logic [15:0] decoded_total;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic push;
    } t_rld_cmd;

    // datapath -> controller
    typedef struct packed {
        logic has_results;
        logic last_result;
        logic out_free;
    } t_rld_status;

endpackage

// ===== rtl/rld_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rld_ctrl
// Controller: takes a byte, then, whenever the output register is free, issues
// one result push per cycle until the byte's results are all in the output register.
// ----------------------------------------------------------------------------
module rld_ctrl
    import rld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_rld_status i_status,
    output t_rld_cmd    o_cmd,
    output logic        o_in_stall
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.push   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_status.has_results) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_cmd.push = i_status.out_free;
                if (i_status.out_free && i_status.last_result) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

// ===== rtl/rld_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rld_datapath
// Decode state, pixel counter, limit register and the output register.
// ----------------------------------------------------------------------------
module rld_datapath
    import rld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  t_in_item    i_in_data,
    input  t_rld_cmd    i_cmd,
    input  logic        i_out_stall,
    output t_rld_status o_status,
    output logic        o_out_valid,
    output t_out_item   o_out_data
);

    localparam logic [1:0] PHASE_CMD     = 2'd0;
    localparam logic [1:0] PHASE_REPEAT  = 2'd1;
    localparam logic [1:0] PHASE_LITERAL = 2'd2;

    logic [15:0] r_limit;
    logic [1:0]  r_phase;
    logic [7:0]  r_run;
    logic [15:0] r_count;
    logic [6:0]  r_left;
    logic [7:0]  r_byte;
    logic        r_eot;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [1:0]  n_phase;
    logic [7:0]  n_run;
    logic [6:0]  pix_cnt;
    logic [15:0] room;
    logic        active;
    logic [15:0] count_inc;
    logic        last_result;
    logic        out_free;

    // Decode of the offered byte against the current phase
    always_comb begin
        n_phase = r_phase;
        n_run   = r_run;
        pix_cnt = 7'd0;
        active  = (r_count < r_limit);
        room    = r_limit - r_count;
        if (active) begin
            case (r_phase)
                PHASE_REPEAT: begin
                    // cut the run short at the limit
                    pix_cnt = (room < {8'd0, r_run}) ? room[6:0] : r_run[6:0];
                    n_phase = PHASE_CMD;
                    n_run   = 8'd0;
                end
                PHASE_LITERAL: begin
                    pix_cnt = 7'd1;
                    n_run   = r_run - 8'd1;
                    if (r_run == 8'd1) begin
                        n_phase = PHASE_CMD;
                    end
                end
                default: begin
                    if (i_in_data.source_byte >= REPEAT_BASE) begin
                        n_phase = PHASE_REPEAT;
                        if ((i_in_data.source_byte[5:0] & REPEAT_COUNT_MASK) == 6'd0) begin
                            n_run = REPEAT_MAX;
                        end else begin
                            n_run = {2'b00, i_in_data.source_byte[5:0] & REPEAT_COUNT_MASK};
                        end
                    end else if (i_in_data.source_byte >= LITERAL_BASE) begin
                        n_phase = PHASE_LITERAL;
                        if ((i_in_data.source_byte[6:0] & LITERAL_COUNT_MASK) == 7'd0) begin
                            n_run = LITERAL_MAX;
                        end else begin
                            n_run = {1'b0, i_in_data.source_byte[6:0] & LITERAL_COUNT_MASK};
                        end
                    end else begin
                        pix_cnt = 7'd1;
                    end
                end
            endcase
        end
        if (i_in_data.end_of_tile) begin
            n_phase = PHASE_CMD;
            n_run   = 8'd0;
        end
    end

    assign count_inc   = r_count + 16'd1;
    assign last_result = (r_left <= 7'd1);
    assign out_free    = !r_out_valid || !i_out_stall;

    assign o_status.has_results = (pix_cnt != 7'd0) || i_in_data.end_of_tile;
    assign o_status.last_result = last_result;
    assign o_status.out_free    = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= PIXEL_LIMIT_RESET;
            r_phase     <= PHASE_CMD;
            r_run       <= 8'd0;
            r_count     <= 16'd0;
            r_left      <= 7'd0;
            r_eot       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_phase <= n_phase;
                r_run   <= n_run;
                r_left  <= pix_cnt;
                r_eot   <= i_in_data.end_of_tile;
            end
            if (i_cmd.push) begin
                if (r_left != 7'd0) begin
                    r_left <= r_left - 7'd1;
                end
                if (last_result && r_eot) begin
                    r_count <= 16'd0;
                end else if (r_left != 7'd0) begin
                    r_count <= count_inc;
                end
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_in_data.source_byte;
        end
        if (i_cmd.push) begin
            if (r_left != 7'd0) begin
                r_out.pixel_valid   <= 1'b1;
                r_out.pixel_value   <= r_byte;
                r_out.decoded_total <= count_inc;
            end else begin
                // end-of-tile beat with no pixel
                r_out.pixel_valid   <= 1'b0;
                r_out.pixel_value   <= 8'd0;
                r_out.decoded_total <= r_count;
            end
            r_out.last_of_item <= last_result;
            r_out.tile_done    <= last_result && r_eot;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_no_push_over_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> out_free)
        else $error("result pushed over a stalled output beat");

    a_accept_push_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.accept && i_cmd.push))
        else $error("accept and push in the same cycle");

    a_left_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= 7'd64)
        else $error("pending pixel count beyond a full repeat run");

    a_tile_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push && last_result && r_eot) |=> (r_count == 16'd0))
        else $error("pixel count not cleared after tile end");

    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("unused decode phase reached");

endmodule

// ===== rtl/run_length_byte_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_length_byte_decoder
// Run-length byte decoder for one tile at a time: repeat, literal-run and
// single-pixel codes, with a per-tile pixel limit.
// ----------------------------------------------------------------------------
// Each accepted byte that gives n results holds the input stalled while the
// single output register is loaded with one result per cycle, whenever the
// downstream stall lets it (n up to 64 for a repeat run, one for a pixel or
// literal byte, one for an end-of-tile byte with no pixel). A byte with no
// result does not stall the input. The pixel limit is written through
// i_cfg_we/i_cfg_data; the user must write it only while the block is idle,
// as the block does not enforce this. It resets to 576 and is kept across tiles.
module run_length_byte_decoder
    import rld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data
);

    t_rld_cmd    cmd;
    t_rld_status status;

    rld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    rld_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the run-length byte decoder. Compressed tiles are
// built from repeat, literal-run and single-pixel codes, with random content,
// noise bytes and tiles cut short. A scoreboard predicts every pixel beat
// from the accepted source bytes and checks each output beat field by field.
// The pixel limit is changed between phases, from zero up to its maximum.
// ----------------------------------------------------------------------------
import rld_pkg::*;

typedef enum logic [1:0] {
    PH_CMD,
    PH_REPEAT,
    PH_LITERAL
} t_decode_phase;

class rld_scoreboard;
    logic [15:0]   pixel_limit;
    t_decode_phase phase;
    logic [7:0]    run_left;
    logic [15:0]   tile_total;
    t_out_item     byte_results[$];
    t_out_item     expected_pixels[$];
    int unsigned   errors;

    function new();
        pixel_limit = PIXEL_LIMIT_RESET;
        phase       = PH_CMD;
        run_left    = '0;
        tile_total  = '0;
        errors      = 0;
    endfunction

    function void emit_pixel(logic [7:0] value);
        t_out_item px;
        tile_total       = tile_total + 16'd1;
        px               = '0;
        px.pixel_valid   = 1'b1;
        px.pixel_value   = value;
        px.decoded_total = tile_total;
        byte_results.push_back(px);
    endfunction

    function void note_byte(t_in_item beat);
        int unsigned room;
        int unsigned count;
        int unsigned i;
        int unsigned last;
        t_out_item   no_pixel;
        byte_results.delete();
        if (tile_total < pixel_limit) begin
            case (phase)
                PH_REPEAT: begin
                    // run is clipped at the limit
                    room  = pixel_limit - tile_total;
                    count = (run_left < room) ? run_left : room;
                    for (i = 0; i < count; i++) emit_pixel(beat.source_byte);
                    phase    = PH_CMD;
                    run_left = '0;
                end
                PH_LITERAL: begin
                    emit_pixel(beat.source_byte);
                    run_left = run_left - 8'd1;
                    if (run_left == 8'd0) phase = PH_CMD;
                end
                default: begin
                    if (beat.source_byte >= REPEAT_BASE) begin
                        run_left = {2'b00, beat.source_byte[5:0] & REPEAT_COUNT_MASK};
                        if (run_left == 8'd0) run_left = REPEAT_MAX;
                        phase = PH_REPEAT;
                    end else if (beat.source_byte >= LITERAL_BASE) begin
                        run_left = {1'b0, beat.source_byte[6:0] & LITERAL_COUNT_MASK};
                        if (run_left == 8'd0) run_left = LITERAL_MAX;
                        phase = PH_LITERAL;
                    end else begin
                        emit_pixel(beat.source_byte);
                    end
                end
            endcase
        end
        if (beat.end_of_tile && byte_results.size() == 0) begin
            no_pixel               = '0;
            no_pixel.decoded_total = tile_total;
            byte_results.push_back(no_pixel);
        end
        if (byte_results.size() > 0) begin
            last = byte_results.size() - 1;
            byte_results[last].last_of_item = 1'b1;
            byte_results[last].tile_done    = beat.end_of_tile;
        end
        foreach (byte_results[k]) expected_pixels.push_back(byte_results[k]);
        if (beat.end_of_tile) begin
            phase      = PH_CMD;
            run_left   = '0;
            tile_total = '0;
        end
    endfunction

    function void check_pixel(t_out_item got);
        t_out_item want;
        if (expected_pixels.size() == 0) begin
            $error("unexpected beat: pixel_value %0h decoded_total %0d",
                   got.pixel_value, got.decoded_total);
            errors++;
            return;
        end
        want = expected_pixels.pop_front();
        if (got.pixel_valid !== want.pixel_valid) begin
            $error("pixel_valid: expected %0d, got %0d", want.pixel_valid, got.pixel_valid);
            errors++;
        end
        if (got.pixel_value !== want.pixel_value) begin
            $error("pixel_value: expected %0h, got %0h", want.pixel_value, got.pixel_value);
            errors++;
        end
        if (got.last_of_item !== want.last_of_item) begin
            $error("last_of_item: expected %0d, got %0d", want.last_of_item, got.last_of_item);
            errors++;
        end
        if (got.tile_done !== want.tile_done) begin
            $error("tile_done: expected %0d, got %0d", want.tile_done, got.tile_done);
            errors++;
        end
        if (got.decoded_total !== want.decoded_total) begin
            $error("decoded_total: expected %0d, got %0d",
                   want.decoded_total, got.decoded_total);
            errors++;
        end
    endfunction
endclass

module tb_top;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned PHASE_BYTES  = 44;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_item    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_data;

    rld_scoreboard sb = new();
    t_in_item      byte_queue[$];
    int unsigned   burst_left = 0;
    int unsigned   cycle_count = 0;
    bit            hold_request = 1'b0;

    run_length_byte_decoder uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // note the source byte before checking, so a same-edge result finds it
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) sb.note_byte(in_data);
            if (out_valid && !out_stall) sb.check_pixel(out_data);
        end
    end

    // receiver: stall modes in random stretches, plus one long hold on request
    initial begin : receiver
        int unsigned mode;
        int unsigned stretch;
        int unsigned hold_left;
        int unsigned step;
        hold_left = 0;
        step      = 0;
        forever begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(10, 120);
            repeat (stretch) begin
                @(posedge clk);
                step++;
                if (hold_left > 0) begin
                    hold_left--;
                    out_stall <= 1'b1;
                end else if (hold_request) begin
                    hold_request = 1'b0;
                    hold_left    = LONG_HOLD;
                    out_stall <= 1'b1;
                end else begin
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 3) == 0);
                        2: out_stall <= ($urandom_range(0, 9) < 6);
                        default: out_stall <= (step % 3 == 2);
                    endcase
                end
            end
        end
    end

    function automatic void push_byte(logic [7:0] value, logic eot);
        t_in_item beat;
        beat.source_byte = value;
        beat.end_of_tile = eot;
        byte_queue.push_back(beat);
    endfunction

    // one tile: mostly well-formed codes, some noise, and a random way to end
    function automatic void build_tile();
        int unsigned n_codes;
        int unsigned n;
        int unsigned k;
        int unsigned i;
        logic [7:0]  field;
        n_codes = $urandom_range(1, 8);
        for (k = 0; k < n_codes; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: push_byte(8'($urandom_range(0, 127)), 1'b0);
                3, 4, 5: begin
                    field = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 63))
                                                        : 8'($urandom_range(1, 8));
                    push_byte(REPEAT_BASE | {2'b00, field[5:0]}, 1'b0);
                    push_byte(8'($urandom_range(0, 255)), 1'b0);
                end
                6, 7, 8: begin
                    field = ($urandom_range(0, 14) == 0) ? 8'($urandom_range(0, 127))
                                                         : 8'($urandom_range(1, 6));
                    n = (field[6:0] == 7'd0) ? 128 : field[6:0];
                    push_byte(LITERAL_BASE | {1'b0, field[6:0]}, 1'b0);
                    for (i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);
                end
                default: push_byte(8'($urandom_range(0, 255)), 1'b0);
            endcase
        end
        case ($urandom_range(0, 7))
            0: push_byte(REPEAT_BASE | 8'($urandom_range(0, 63)), 1'b1);
            1: begin
                // literal run cut by the end of the tile
                n = $urandom_range(3, 10);
                k = $urandom_range(1, n - 1);
                push_byte(LITERAL_BASE | 8'(n), 1'b0);
                for (i = 0; i < k; i++) push_byte(8'($urandom_range(0, 255)), i == k - 1);
            end
            2: push_byte(8'($urandom_range(0, 255)), 1'b1);
            default: byte_queue[byte_queue.size() - 1].end_of_tile = 1'b1;
        endcase
    endfunction

    task automatic send_queue();
        t_in_item    beat;
        int unsigned gap;
        while (byte_queue.size() != 0) begin
            beat = byte_queue.pop_front();
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 20)
                                                  : $urandom_range(1, 4);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(1, 12);
            end
            burst_left--;
            in_valid <= 1'b1;
            in_data  <= beat;
            @(posedge clk);
            while (in_stall) @(posedge clk);
        end
        in_valid <= 1'b0;
    endtask

    // the edge after the last accept lets the monitor note that beat first
    task automatic wait_idle();
        @(posedge clk);
        while (sb.expected_pixels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(logic [15:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.pixel_limit = value;
    endtask

    initial begin : stimulus
        logic [15:0] limits[7];
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, at the reset limit
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'hC0, 1'b0);     // repeat of 64
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);     // repeat of 63
        push_byte(8'h00, 1'b0);
        push_byte(8'h81, 1'b0);     // literal of one; the next byte looks like a command
        push_byte(8'hC3, 1'b0);
        push_byte(8'h82, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7E, 1'b0);
        push_byte(8'hC2, 1'b1);     // repeat with no value at end of tile
        push_byte(8'h84, 1'b0);
        push_byte(8'h11, 1'b0);
        push_byte(8'h22, 1'b1);     // literal cut short
        push_byte(8'h85, 1'b1);     // tile ends on a command
        push_byte(8'h42, 1'b1);
        send_queue();
        wait_idle();

        // directed, limit reached part-way through a repeat
        write_limit(16'd3);
        push_byte(8'hC5, 1'b0);
        push_byte(8'h33, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'hC1, 1'b0);
        push_byte(8'h02, 1'b0);
        push_byte(8'h00, 1'b1);
        send_queue();
        wait_idle();

        limits[0] = 16'hFFFF;
        limits[1] = 16'd0;
        limits[2] = 16'd1;
        limits[3] = 16'($urandom_range(2, 40));
        limits[4] = 16'($urandom_range(41, 700));
        limits[5] = 16'($urandom_range(2, 40));
        limits[6] = PIXEL_LIMIT_RESET;
        foreach (limits[p]) begin
            write_limit(limits[p]);
            // fill the block up against a held-off receiver
            if (p == 0) hold_request = 1'b1;
            while (byte_queue.size() < PHASE_BYTES) build_tile();
            send_queue();
            wait_idle();
        end

        if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
